>>> hdl/fac_pkg.sv
// Shared types and constants of the flow acceleration classifier.
package fac_pkg;

  localparam int AGE_MAX_W = 10;

  localparam logic [1:0] ACT_CLASSIFY = 2'd0;
  localparam logic [1:0] ACT_BLOCK_WR = 2'd1;
  localparam logic [1:0] ACT_ALLOW_WR = 2'd2;

  localparam logic [2:0] DEC_MISS         = 3'd0;
  localparam logic [2:0] DEC_BOTH_PRIVATE = 3'd1;
  localparam logic [2:0] DEC_BLOCKED      = 3'd2;
  localparam logic [2:0] DEC_HOT          = 3'd3;
  localparam logic [2:0] DEC_PRE          = 3'd4;
  localparam logic [2:0] DEC_PROMOTED     = 3'd5;
  localparam logic [2:0] DEC_NEW          = 3'd6;

  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_DST  = 2'd1;
  localparam logic [1:0] SIDE_SRC  = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic        wr;
    logic [31:0] prefix;
    logic [5:0]  len;
    logic        valid;
    logic [31:0] addr;
  } match_ctl_t;

  typedef struct packed {
    logic                 touch;
    logic                 wr;
    logic                 bump;
    logic [AGE_MAX_W-1:0] old_age;
    logic [31:0]          addr;
    logic [63:0]          now;
  } cache_ctl_t;

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    len_mask = ~(32'hFFFF_FFFF >> len);
  endfunction

  function automatic logic is_private(input logic [31:0] a);
    is_private = ((a & 32'hFF00_0000) == 32'h7F00_0000) ||
                 ((a & 32'hFF00_0000) == 32'h0A00_0000) ||
                 ((a & 32'hFFF0_0000) == 32'hAC10_0000) ||
                 ((a & 32'hFFFF_0000) == 32'hC0A8_0000);
  endfunction

endpackage

>>> hdl/fac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fac_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> hdl/fac_match_cell.sv
// One blacklist prefix cell: stores an entry and matches the lookup address.
module fac_match_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  fac_pkg::match_ctl_t ctl,
  input  logic               sel,
  output logic               hit
);

  logic [31:0] prefix_r;
  logic [5:0]  len_r;
  logic        valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.wr && sel) begin
      valid_r <= ctl.valid;
    end
    if (ctl.wr && sel) begin
      prefix_r <= ctl.prefix;
      len_r    <= ctl.len;
    end
  end

  assign hit = valid_r && (((ctl.addr ^ prefix_r) & fac_pkg::len_mask(len_r)) == 32'd0);

endmodule

>>> hdl/fac_cache_cell.sv
// One cache cell: address, valid bit, LRU age and sighting statistics.
module fac_cache_cell #(
  parameter int AGE_W = 6,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fac_pkg::cache_ctl_t ctl,
  input  logic               sel,
  output logic               hit,
  output logic               valid,
  output logic [AGE_W-1:0]   age,
  output logic [15:0]        count,
  output logic [63:0]        seen_ns
);

  logic [31:0]      addr_r;
  logic             valid_r;
  logic [AGE_W-1:0] age_r;
  logic [15:0]      count_r;
  logic [63:0]      first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= AGE_W'(INDEX);
    end else begin
      if (ctl.wr && sel) begin
        valid_r <= 1'b1;
      end
      if (ctl.touch) begin
        if (sel) begin
          age_r <= '0;
        end else if (age_r < ctl.old_age[AGE_W-1:0]) begin
          age_r <= age_r + 1'b1;
        end
      end
    end
    if (ctl.wr && sel) begin
      addr_r  <= ctl.addr;
      first_r <= ctl.now;
      count_r <= 16'd1;
    end else if (ctl.bump && sel && count_r != fac_pkg::COUNT_MAX) begin
      count_r <= count_r + 16'd1;
    end
  end

  assign hit     = valid_r && (addr_r == ctl.addr);
  assign valid   = valid_r;
  assign age     = age_r;
  assign count   = count_r;
  assign seen_ns = first_r;

endmodule

>>> hdl/flow_accel_classifier_unit.sv
// Top level of the flow acceleration classifier: sequencer, cell rows and whitelist RAM.
// When the caches and blacklist do not decide, the whitelist RAM is swept one entry a
// cycle for each side. One item is worked on at a time; the sequencer returns to idle
// as a result is registered, and the output register lets the next request in while
// that result waits. After reset a clearing pass writes zero to every whitelist RAM
// entry; no request is taken until it ends.
module flow_accel_classifier_unit #(
  parameter int BLOCK_ENTRIES = 64,
  parameter int ALLOW_ENTRIES = 1024,
  parameter int HOT_ENTRIES   = 64,
  parameter int PRE_ENTRIES   = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // src_addr, dst_addr, now_ns, entry_index, entry_prefix, entry_length, entry_valid
  input  logic [183:0] in_tdata,
  // action
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // accelerate, matched_side, decision
  output logic [7:0]   out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int HOT_AW = (HOT_ENTRIES > 1) ? $clog2(HOT_ENTRIES) : 1;
  localparam int PRE_AW = (PRE_ENTRIES > 1) ? $clog2(PRE_ENTRIES) : 1;
  localparam int AL_AW  = (ALLOW_ENTRIES > 1) ? $clog2(ALLOW_ENTRIES) : 1;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_PROMO = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [15:0] thr_r;
  logic [63:0] ivl_r;
  logic [1:0]  act_r;
  logic [31:0] src_r, dst_r, pfx_r;
  logic [63:0] now_r;
  logic [9:0]  idx_r;
  logic [5:0]  len_r;
  logic        en_r;
  logic        side_r, side_nxt;
  logic        dblk_r, dblk_nxt;
  logic [PRE_ENTRIES-1:0] psel_r, psel_nxt;
  logic [AL_AW:0] cnt_r, cnt_nxt;
  logic        rdv_r, rdv_nxt;
  logic        res_acc_r, res_acc_nxt;
  logic [1:0]  res_side_r, res_side_nxt;
  logic [2:0]  res_dec_r, res_dec_nxt;
  logic        out_valid_r;
  logic [5:0]  out_data_r;

  logic [31:0] cur_addr;
  logic        in_acc;
  logic [5:0]  in_len;

  fac_pkg::match_ctl_t bctl;
  fac_pkg::cache_ctl_t hctl, pctl;
  logic [BLOCK_ENTRIES-1:0] bsel, bhit;
  logic [HOT_ENTRIES-1:0]   hsel, hhit, hval, hold, hvic;
  logic [PRE_ENTRIES-1:0]   psel, phit, pval, pold, pvic;
  logic [HOT_AW-1:0] hage [HOT_ENTRIES];
  logic [PRE_AW-1:0] page [PRE_ENTRIES];
  logic [15:0]       pcnt [PRE_ENTRIES];
  logic [63:0]       pfst [PRE_ENTRIES];
  logic [15:0]       hcnt_nc [HOT_ENTRIES];
  logic [63:0]       hfst_nc [HOT_ENTRIES];

  logic              ram_we;
  logic [AL_AW-1:0]  ram_waddr, ram_raddr;
  logic [38:0]       ram_wdata, ram_rdata;
  logic              al_hit;

  logic [HOT_AW-1:0] hage_hit, hage_vic;
  logic [PRE_AW-1:0] page_hit, page_vic;
  logic [15:0]       sel_cnt;
  logic [63:0]       sel_fst;
  logic              fail, fail_blk, done_yes;
  logic [2:0]        yes_dec;

  assign in_len    = (in_tdata[175:170] > 6'd32) ? 6'd32 : in_tdata[175:170];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cur_addr  = side_r ? src_r : dst_r;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[3] ? ivl_r : {48'd0, thr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd10;
      ivl_r <= 64'd1000000000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[3]) begin
        ivl_r <= cfg_pwdata;
      end else begin
        thr_r <= cfg_pwdata[15:0];
      end
    end
  end

  // Blacklist cell row.
  always_comb begin
    bctl.wr     = (state_r == S_LOOK) && (act_r == fac_pkg::ACT_BLOCK_WR);
    bctl.prefix = pfx_r;
    bctl.len    = len_r;
    bctl.valid  = en_r;
    bctl.addr   = cur_addr;
  end

  for (genvar i = 0; i < BLOCK_ENTRIES; i++) begin : g_blk
    assign bsel[i] = (32'(idx_r) == i);
    fac_match_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(bctl), .sel(bsel[i]), .hit(bhit[i])
    );
  end

  // Cache cell rows.
  for (genvar i = 0; i < HOT_ENTRIES; i++) begin : g_hot
    fac_cache_cell #(.AGE_W(HOT_AW), .INDEX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(hctl), .sel(hsel[i]), .hit(hhit[i]),
      .valid(hval[i]), .age(hage[i]), .count(hcnt_nc[i]), .seen_ns(hfst_nc[i])
    );
    assign hold[i] = (hage[i] == HOT_AW'(HOT_ENTRIES - 1));
  end

  for (genvar i = 0; i < PRE_ENTRIES; i++) begin : g_pre
    fac_cache_cell #(.AGE_W(PRE_AW), .INDEX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(pctl), .sel(psel[i]), .hit(phit[i]),
      .valid(pval[i]), .age(page[i]), .count(pcnt[i]), .seen_ns(pfst[i])
    );
    assign pold[i] = (page[i] == PRE_AW'(PRE_ENTRIES - 1));
  end

  assign hvic = (|(~hval)) ? ((~hval) & (hval + 1'b1)) : hold;
  assign pvic = (|(~pval)) ? ((~pval) & (pval + 1'b1)) : pold;

  always_comb begin
    hage_hit = '0;
    hage_vic = '0;
    for (int i = 0; i < HOT_ENTRIES; i++) begin
      if (hhit[i]) hage_hit = hage_hit | hage[i];
      if (hvic[i]) hage_vic = hage_vic | hage[i];
    end
  end

  always_comb begin
    page_hit = '0;
    page_vic = '0;
    sel_cnt  = '0;
    sel_fst  = '0;
    for (int i = 0; i < PRE_ENTRIES; i++) begin
      if (phit[i]) page_hit = page_hit | page[i];
      if (pvic[i]) page_vic = page_vic | page[i];
      if (psel_r[i]) begin
        sel_cnt = sel_cnt | pcnt[i];
        sel_fst = sel_fst | pfst[i];
      end
    end
  end

  // Whitelist RAM and its clearing pass.
  fac_ram #(.WIDTH(39), .DEPTH(ALLOW_ENTRIES)) u_allow (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata_r(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AL_AW-1:0];
    ram_wdata = '0;
    if (state_r == S_CLR) begin
      ram_we = 1'b1;
    end else if (state_r == S_LOOK && act_r == fac_pkg::ACT_ALLOW_WR &&
                 32'(idx_r) < ALLOW_ENTRIES) begin
      ram_we    = 1'b1;
      ram_waddr = AL_AW'(idx_r);
      ram_wdata = {en_r, len_r, pfx_r};
    end
  end

  assign ram_raddr = cnt_r[AL_AW-1:0];
  assign al_hit = ram_rdata[38] &&
                  (((cur_addr ^ ram_rdata[31:0]) & fac_pkg::len_mask(ram_rdata[37:32])) == 32'd0);

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    side_nxt     = side_r;
    dblk_nxt     = dblk_r;
    psel_nxt     = psel_r;
    cnt_nxt      = cnt_r;
    rdv_nxt      = 1'b0;
    res_acc_nxt  = res_acc_r;
    res_side_nxt = res_side_r;
    res_dec_nxt  = res_dec_r;
    fail         = 1'b0;
    fail_blk     = 1'b0;
    done_yes     = 1'b0;
    yes_dec      = fac_pkg::DEC_MISS;
    hctl.touch = 1'b0; hctl.wr = 1'b0; hctl.bump = 1'b0;
    hctl.old_age = fac_pkg::AGE_MAX_W'(hage_hit);
    hctl.addr = cur_addr; hctl.now = now_r;
    hsel = hhit;
    pctl.touch = 1'b0; pctl.wr = 1'b0; pctl.bump = 1'b0;
    pctl.old_age = fac_pkg::AGE_MAX_W'(page_hit);
    pctl.addr = cur_addr; pctl.now = now_r;
    psel = phit;

    unique case (state_r)
      S_CLR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AL_AW + 1)'(ALLOW_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_LOOK;
          side_nxt  = 1'b0;
          dblk_nxt  = 1'b0;
        end
      end
      S_LOOK: begin
        res_acc_nxt  = 1'b0;
        res_side_nxt = fac_pkg::SIDE_NONE;
        res_dec_nxt  = fac_pkg::DEC_MISS;
        if (act_r != fac_pkg::ACT_CLASSIFY) begin
          state_nxt = S_DONE;
        end else if (fac_pkg::is_private(src_r) && fac_pkg::is_private(dst_r)) begin
          res_dec_nxt = fac_pkg::DEC_BOTH_PRIVATE;
          state_nxt   = S_DONE;
        end else if (|bhit) begin
          fail     = 1'b1;
          fail_blk = 1'b1;
        end else if (fac_pkg::is_private(cur_addr)) begin
          fail = 1'b1;
        end else if (|hhit) begin
          hctl.touch = 1'b1;
          done_yes   = 1'b1;
          yes_dec    = fac_pkg::DEC_HOT;
        end else if (|phit) begin
          pctl.touch = 1'b1;
          pctl.bump  = 1'b1;
          psel_nxt   = phit;
          state_nxt  = S_PROMO;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_SWEEP;
        end
      end
      S_PROMO: begin
        done_yes = 1'b1;
        if (sel_cnt >= thr_r && (now_r - sel_fst) > ivl_r) begin
          hsel         = hvic;
          hctl.wr      = 1'b1;
          hctl.touch   = 1'b1;
          hctl.old_age = fac_pkg::AGE_MAX_W'(hage_vic);
          yes_dec      = fac_pkg::DEC_PROMOTED;
        end else begin
          yes_dec = fac_pkg::DEC_PRE;
        end
      end
      S_SWEEP: begin
        if (cnt_r < (AL_AW + 1)'(ALLOW_ENTRIES)) begin
          cnt_nxt = cnt_r + 1'b1;
          rdv_nxt = 1'b1;
        end
        if (rdv_r && al_hit) begin
          rdv_nxt      = 1'b0;
          psel         = pvic;
          pctl.wr      = 1'b1;
          pctl.touch   = 1'b1;
          pctl.old_age = fac_pkg::AGE_MAX_W'(page_vic);
          done_yes     = 1'b1;
          yes_dec      = fac_pkg::DEC_NEW;
        end else if (!rdv_r && cnt_r == (AL_AW + 1)'(ALLOW_ENTRIES)) begin
          fail = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done_yes) begin
      res_acc_nxt  = 1'b1;
      res_side_nxt = side_r ? fac_pkg::SIDE_SRC : fac_pkg::SIDE_DST;
      res_dec_nxt  = yes_dec;
      state_nxt    = S_DONE;
    end
    if (fail) begin
      if (!side_r) begin
        dblk_nxt  = fail_blk;
        side_nxt  = 1'b1;
        state_nxt = S_LOOK;
      end else begin
        res_acc_nxt = 1'b0;
        state_nxt   = S_DONE;
        if (dblk_r) begin
          res_side_nxt = fac_pkg::SIDE_DST;
          res_dec_nxt  = fac_pkg::DEC_BLOCKED;
        end else if (fail_blk) begin
          res_side_nxt = fac_pkg::SIDE_SRC;
          res_dec_nxt  = fac_pkg::DEC_BLOCKED;
        end else begin
          res_side_nxt = fac_pkg::SIDE_NONE;
          res_dec_nxt  = fac_pkg::DEC_MISS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      rdv_r       <= 1'b0;
      side_r      <= 1'b0;
      dblk_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rdv_r   <= rdv_nxt;
      side_r  <= side_nxt;
      dblk_r  <= dblk_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    psel_r     <= psel_nxt;
    res_acc_r  <= res_acc_nxt;
    res_side_r <= res_side_nxt;
    res_dec_r  <= res_dec_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {res_dec_r, res_side_r, res_acc_r};
    end
    if (in_acc) begin
      act_r <= in_tuser;
      src_r <= in_tdata[31:0];
      dst_r <= in_tdata[63:32];
      now_r <= in_tdata[127:64];
      idx_r <= in_tdata[137:128];
      pfx_r <= in_tdata[169:138];
      len_r <= in_len;
      en_r  <= in_tdata[176];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_tready) else $error("request taken during clearing pass");
  a_hot_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hhit)) else $error("address held in two hot cells");
  a_pre_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(phit)) else $error("address held in two pre cells");
  a_accel_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[0]) |->
      (out_data_r[5:3] == fac_pkg::DEC_HOT || out_data_r[5:3] == fac_pkg::DEC_PRE ||
       out_data_r[5:3] == fac_pkg::DEC_PROMOTED || out_data_r[5:3] == fac_pkg::DEC_NEW))
    else $error("accelerated result with a refusing decision");

endmodule
